// File: design/uej_pkg.sv
// Shared types, constants and the byte formatter for the EUC-JP encoder.
`default_nettype none
package uej_pkg;

    localparam int TRIE_DEPTH_DEF = 32768;
    localparam int ADDR_SUM_W     = 17;
    localparam int LVL_W          = 2;
    localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;

    localparam logic       FUNC_LOAD   = 1'b0;
    localparam logic       FUNC_ENCODE = 1'b1;

    localparam logic [15:0] CODE_UNDEF   = 16'hffff;
    localparam logic [15:0] CODE_1B_LIM  = 16'h0080;
    localparam logic [15:0] CODE_SS2_LIM = 16'h0100;
    localparam logic [15:0] CODE_212_MIN = 16'h8000;
    localparam logic [15:0] HIGH_BITS    = 16'h8080;
    localparam logic [7:0]  BYTE_UNKNOWN = 8'h3f;
    localparam logic [7:0]  BYTE_SS2     = 8'h8e;
    localparam logic [7:0]  BYTE_SS3     = 8'h8f;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_first;
        logic             rd_next;
        logic             emit_now;
        logic             hold_save;
        logic             emit_hold;
        logic [LVL_W-1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic emit_free;
    } stat_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } emit_t;

    // bytes go out b0 first
    function automatic emit_t encode(input logic [15:0] code);
        emit_t       e;
        logic [15:0] both;
        both = code | HIGH_BITS;
        e    = '0;
        if (code == CODE_UNDEF) begin
            e.cnt = 2'd1;
            e.b0  = BYTE_UNKNOWN;
        end else if (code < CODE_1B_LIM) begin
            e.cnt = 2'd1;
            e.b0  = code[7:0];
        end else if (code < CODE_SS2_LIM) begin
            e.cnt = 2'd2;
            e.b0  = BYTE_SS2;
            e.b1  = code[7:0];
        end else if (code < CODE_212_MIN) begin
            e.cnt = 2'd2;
            e.b0  = both[15:8];
            e.b1  = both[7:0];
        end else begin
            e.cnt = 2'd3;
            e.b0  = BYTE_SS3;
            e.b1  = both[15:8];
            e.b2  = both[7:0];
        end
        return e;
    endfunction

endpackage
`default_nettype wire

// File: design/unicode_to_eucjp_encoder_top.sv
// Encoder walk: an accepted encode word starts a trie walk from the top level; a zero or out-of-range
// branch ends the walk early. A full walk is four dependent trie reads on the single memory read
// port, so a new encode word is taken only once the walk ends; load words go in at one per cycle
// while the controller is ready; bytes leave one per cycle while the receiver is ready.
// A finished character waits in the output queue while the next walk runs; input stalls if not.
// Reset clears the controller and output queue; the trie memory is not cleared.
`default_nettype none
module unicode_to_eucjp_encoder_top #(
    parameter int TRIE_DEPTH = uej_pkg::TRIE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // table_addr[14:0], table_word[30:15], char_code[46:31], 0
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // out_byte[7:0]
    output logic             m_axis_tlast
);

    uej_pkg::cmd_t  cmd;
    uej_pkg::stat_t stat;

    uej_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .func     (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    uej_datapath #(
        .TRIE_DEPTH (TRIE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .table_addr (s_axis_tdata[14:0]),
        .table_word (s_axis_tdata[30:15]),
        .char_code  (s_axis_tdata[46:31]),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

endmodule
`default_nettype wire

// File: design/uej_ctrl.sv
// Controller: accepts words and sequences the four-level trie walk.
`default_nettype none
module uej_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          func,
    output logic               in_ready,
    input  uej_pkg::stat_t     stat,
    output uej_pkg::cmd_t      cmd
);

    uej_pkg::state_t state_reg, state_next;
    logic [uej_pkg::LVL_W-1:0] lvl_reg, lvl_next;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uej_pkg::ST_IDLE;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.lvl  = lvl_reg;
        case (state_reg)
            uej_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            uej_pkg::ST_LOOK:
            begin
                if (stat.done)
                begin
                    if (stat.emit_free)
                    begin
                        cmd.emit_now = 1'b1;
                        in_ready     = 1'b1;
                    end
                    else
                    begin
                        cmd.hold_save = 1'b1;
                    end
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            uej_pkg::ST_HOLD:
            begin
                if (stat.emit_free)
                begin
                    cmd.emit_hold = 1'b1;
                    in_ready      = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        accept       = in_valid && in_ready;
        cmd.wr_en    = accept && (func == uej_pkg::FUNC_LOAD);
        cmd.rd_first = accept && (func == uej_pkg::FUNC_ENCODE);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        case (state_reg)
            uej_pkg::ST_IDLE:
            begin
                if (cmd.rd_first)
                    state_next = uej_pkg::ST_LOOK;
            end
            uej_pkg::ST_LOOK:
            begin
                if (stat.done)
                begin
                    if (!stat.emit_free)
                        state_next = uej_pkg::ST_HOLD;
                    else if (cmd.rd_first)
                        state_next = uej_pkg::ST_LOOK;
                    else
                        state_next = uej_pkg::ST_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            uej_pkg::ST_HOLD:
            begin
                if (stat.emit_free)
                    state_next = cmd.rd_first ? uej_pkg::ST_LOOK : uej_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = uej_pkg::ST_IDLE;
            end
        endcase
        if (cmd.rd_first)
            lvl_next = uej_pkg::LVL_TOP;
    end

endmodule
`default_nettype wire

// File: design/uej_datapath.sv
// Datapath: trie memory, walk address logic and the output byte queue.
`default_nettype none
module uej_datapath #(
    parameter int TRIE_DEPTH = uej_pkg::TRIE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  uej_pkg::cmd_t    cmd,
    output uej_pkg::stat_t   stat,
    input  wire logic [14:0] table_addr,
    input  wire logic [15:0] table_word,
    input  wire logic [15:0] char_code,
    output logic [7:0]       out_byte,
    output logic             out_last,
    output logic             out_valid,
    input  wire logic        out_ready
);

    localparam int AW = $clog2(TRIE_DEPTH);
    localparam logic [uej_pkg::ADDR_SUM_W-1:0] DEPTH_LIM =
        uej_pkg::ADDR_SUM_W'(TRIE_DEPTH);

    logic [15:0] mem [TRIE_DEPTH];
    logic [15:0] rd_data_reg;
    logic [15:0] key_reg;
    logic [15:0] code_reg;
    logic [7:0]  q_reg [3];
    logic [1:0]  n_reg;

    logic [uej_pkg::ADDR_SUM_W-1:0] wr_full, first_full, next_sum;
    logic [AW-1:0]  rd_addr;
    logic [3:0]     nib;
    logic [15:0]    code_now;
    logic           oob;
    logic           pop;
    logic           load;
    uej_pkg::emit_t enc;

    assign wr_full    = uej_pkg::ADDR_SUM_W'(table_addr);
    assign first_full = uej_pkg::ADDR_SUM_W'(char_code[15:12]);

    // nibble for the level read next
    always_comb
    begin
        case (cmd.lvl)
            2'd3:    nib = key_reg[11:8];
            2'd2:    nib = key_reg[7:4];
            default: nib = key_reg[3:0];
        endcase
    end

    assign next_sum = uej_pkg::ADDR_SUM_W'(rd_data_reg) + uej_pkg::ADDR_SUM_W'(nib);
    assign oob      = next_sum >= DEPTH_LIM;
    assign rd_addr  = cmd.rd_first ? first_full[AW-1:0] : next_sum[AW-1:0];

    assign stat.done = (cmd.lvl == '0) || (rd_data_reg == '0) || oob;
    assign code_now  = (cmd.lvl == '0) ? rd_data_reg : uej_pkg::CODE_UNDEF;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && (wr_full < DEPTH_LIM))
            mem[wr_full[AW-1:0]] <= table_word;
        if (cmd.rd_first || cmd.rd_next)
            rd_data_reg <= mem[rd_addr];
        if (cmd.rd_first)
            key_reg <= char_code;
        if (cmd.hold_save)
            code_reg <= code_now;
    end

    // output queue, up to three bytes of one character
    assign pop            = out_valid && out_ready;
    assign stat.emit_free = (n_reg == 2'd0) || ((n_reg == 2'd1) && out_ready);
    assign load           = cmd.emit_now || cmd.emit_hold;
    assign enc            = uej_pkg::encode(cmd.emit_hold ? code_reg : code_now);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg[0] <= enc.b0;
            q_reg[1] <= enc.b1;
            q_reg[2] <= enc.b2;
        end
        else if (pop)
        begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= 2'd0;
        else if (load)
            n_reg <= enc.cnt;
        else if (pop)
            n_reg <= n_reg - 2'd1;
    end

    assign out_byte  = q_reg[0];
    assign out_last  = (n_reg == 2'd1);
    assign out_valid = (n_reg != 2'd0);

endmodule
`default_nettype wire
